/* hw/rtl/alm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

   // Request and node payload widths fixed by the request format.
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int OP_W    = 2;
   localparam int STS_W   = 2;
   localparam int REQ_W   = 40;

   // Operation codes carried in the request.
   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 2'd0,
      OP_INSERT   = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DEL_SUCC = 2'd3
   } op_type;

   // Completion status returned with each response.
   typedef enum logic [STS_W-1:0] {
      STS_OK      = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_BAD_POS = 2'd2,
      STS_NO_LINK = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_POS,
      S_TAKE,
      S_LINK,
      S_TAIL,
      S_FIND,
      S_SUCC,
      S_FREE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/alm_node_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module alm_node_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One read port with registered data.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/alm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module alm_ctrl
   import alm_pkg::*;
#(
   parameter int NODES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire op_type                               op,
   input  wire logic [POS_W-1:0]                     pos,
   input  wire logic [VALUE_W-1:0]                   val,
   output logic                                      idle,
   output logic                                      res_valid,
   input  wire logic                                 res_take,
   output status_type                                res_status,
   output logic [$clog2(NODES+1)-1:0]                res_slot,
   output logic [VALUE_W-1:0]                        res_value,
   output logic [$clog2(NODES+1)-1:0]                res_free_head,
   output logic                                      ram_we,
   output logic [$clog2(NODES)-1:0]                  ram_waddr,
   output logic [$clog2(NODES+1)+VALUE_W:0]          ram_wdata,
   output logic [$clog2(NODES)-1:0]                  ram_raddr,
   input  wire logic [$clog2(NODES+1)+VALUE_W:0]     ram_rdata
);

   localparam int LW = $clog2(NODES + 1);
   localparam int AW = $clog2(NODES);
   localparam logic [LW-1:0] NIL = LW'(NODES);
   localparam logic [LW-1:0] LAST = LW'(NODES - 1);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      free_ff, free_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic               force_ff, force_in;
   logic [LW-1:0]      plink_ff, plink_in;
   logic [VALUE_W-1:0] pvalue_ff, pvalue_in;
   logic [LW-1:0]      tgt_ff, tgt_in;
   status_type         status_ff, status_in;
   logic [LW-1:0]      slot_ff, slot_in;
   logic [VALUE_W-1:0] vout_ff, vout_in;

   // Fields of the node word that was read in the previous cycle.
   logic               rd_used;
   logic [LW-1:0]      rd_link;
   logic [VALUE_W-1:0] rd_value;

   // Shared decisions of the sequencer.
   logic          pos_in_range;
   logic [LW-1:0] pos_link;
   logic [AW-1:0] pos_addr;
   logic          free_nil;
   logic          head_nil;
   logic          rd_link_nil;
   logic          head_is_pos;
   logic          rd_hits_pos;
   logic          last_step;

   assign rd_used  = ram_rdata[LW+VALUE_W];
   assign rd_link  = ram_rdata[VALUE_W +: LW];
   assign rd_value = ram_rdata[VALUE_W-1:0];

   assign pos_in_range = int'(pos_ff) < NODES;
   assign pos_link     = LW'(pos_ff);
   assign pos_addr     = AW'(pos_ff);
   assign free_nil     = !(free_ff < NIL);
   assign head_nil     = !(head_ff < NIL);
   assign rd_link_nil  = !(rd_link < NIL);
   assign head_is_pos  = head_ff == pos_link;
   assign rd_hits_pos  = rd_link == pos_link;
   assign last_step    = cnt_ff == LAST;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (last_step) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (op_ff == OP_APPEND) begin
               state_in = free_nil ? S_DONE : S_TAKE;
            end else begin
               state_in = pos_in_range ? S_POS : S_DONE;
            end
         end
         S_POS: begin
            state_in = S_DONE;
            if (rd_used) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!free_nil) state_in = S_TAKE;
                  end
                  OP_DELETE: begin
                     if (!head_is_pos && !head_nil) state_in = S_FIND;
                  end
                  OP_DEL_SUCC: begin
                     if (!rd_link_nil) state_in = S_SUCC;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TAKE: begin
            if (op_ff == OP_APPEND) begin
               state_in = head_nil ? S_DONE : S_TAIL;
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            state_in = S_DONE;
         end
         S_TAIL: begin
            if (rd_link_nil || force_ff) state_in = S_DONE;
         end
         S_FIND: begin
            if (rd_hits_pos) begin
               state_in = S_FREE;
            end else if (rd_link_nil || last_step) begin
               state_in = S_DONE;
            end
         end
         S_SUCC: begin
            state_in = S_FREE;
         end
         S_FREE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Memory commands and datapath register updates.
   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      force_in  = force_ff;
      plink_in  = plink_ff;
      pvalue_in = pvalue_ff;
      tgt_in    = tgt_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      vout_in   = vout_ff;
      ram_we    = 1'b0;
      ram_waddr = AW'(cur_ff);
      ram_wdata = '0;
      ram_raddr = AW'(cur_ff);
      case (state_ff)
         S_INIT: begin
            // Clearing pass: node i links to i + 1, the last one to null.
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_ff);
            ram_wdata = {1'b0, cnt_ff + LW'(1), {VALUE_W{1'b0}}};
            cnt_in    = cnt_ff + LW'(1);
         end
         S_IDLE: begin
            if (start) begin
               op_in     = op;
               pos_in    = pos;
               val_in    = val;
               status_in = STS_OK;
               slot_in   = NIL;
               vout_in   = '0;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_APPEND) begin
               if (free_nil) status_in = STS_NO_FREE;
               ram_raddr = AW'(free_ff);
            end else begin
               if (!pos_in_range) status_in = STS_BAD_POS;
               ram_raddr = pos_addr;
            end
         end
         S_POS: begin
            plink_in  = rd_link;
            pvalue_in = rd_value;
            if (!rd_used) begin
               status_in = STS_BAD_POS;
            end else begin
               case (op_ff)
                  OP_INSERT: begin
                     if (free_nil) status_in = STS_NO_FREE;
                     ram_raddr = AW'(free_ff);
                  end
                  OP_DELETE: begin
                     if (head_is_pos) begin
                        // Removing the head: no predecessor to patch.
                        head_in   = rd_link;
                        ram_we    = 1'b1;
                        ram_waddr = pos_addr;
                        ram_wdata = {1'b0, free_ff, {VALUE_W{1'b0}}};
                        free_in   = pos_link;
                        slot_in   = pos_link;
                        vout_in   = rd_value;
                     end else if (head_nil) begin
                        status_in = STS_NO_LINK;
                     end else begin
                        cur_in    = head_ff;
                        cnt_in    = '0;
                        ram_raddr = AW'(head_ff);
                     end
                  end
                  OP_DEL_SUCC: begin
                     if (rd_link_nil) status_in = STS_NO_LINK;
                     cur_in    = rd_link;
                     tgt_in    = rd_link;
                     ram_raddr = AW'(rd_link);
                  end
                  default: begin
                     status_in = STS_BAD_POS;
                  end
               endcase
            end
         end
         S_TAKE: begin
            // The word read holds the next free node.
            free_in   = rd_link;
            slot_in   = free_ff;
            ram_we    = 1'b1;
            ram_waddr = AW'(free_ff);
            if (op_ff == OP_APPEND) begin
               ram_wdata = {1'b1, NIL, val_ff};
               if (head_nil) begin
                  head_in = free_ff;
               end else begin
                  cur_in    = head_ff;
                  cnt_in    = '0;
                  force_in  = 1'b0;
                  ram_raddr = AW'(head_ff);
               end
            end else begin
               ram_wdata = {1'b1, plink_ff, val_ff};
            end
         end
         S_LINK: begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr;
            ram_wdata = {1'b1, slot_ff, pvalue_ff};
         end
         S_TAIL: begin
            if (rd_link_nil || force_ff) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(cur_ff);
               ram_wdata = {rd_used, slot_ff, rd_value};
            end else begin
               cur_in    = rd_link;
               cnt_in    = cnt_ff + LW'(1);
               force_in  = last_step;
               ram_raddr = AW'(rd_link);
            end
         end
         S_FIND: begin
            if (rd_hits_pos) begin
               // Predecessor found: bypass the removed node.
               ram_we    = 1'b1;
               ram_waddr = AW'(cur_ff);
               ram_wdata = {rd_used, plink_ff, rd_value};
               tgt_in    = pos_link;
               vout_in   = pvalue_ff;
            end else if (rd_link_nil || last_step) begin
               status_in = STS_NO_LINK;
            end else begin
               cur_in    = rd_link;
               cnt_in    = cnt_ff + LW'(1);
               ram_raddr = AW'(rd_link);
            end
         end
         S_SUCC: begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr;
            ram_wdata = {1'b1, rd_link, pvalue_ff};
            vout_in   = rd_value;
         end
         S_FREE: begin
            // Push the removed node onto the free list.
            ram_we    = 1'b1;
            ram_waddr = AW'(tgt_ff);
            ram_wdata = {1'b0, free_ff, {VALUE_W{1'b0}}};
            free_in   = tgt_ff;
            slot_in   = tgt_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Response fields.
   assign idle          = state_ff == S_IDLE;
   assign res_valid     = state_ff == S_DONE;
   assign res_status    = status_ff;
   assign res_slot      = slot_ff;
   assign res_value     = vout_ff;
   assign res_free_head = free_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         head_ff  <= NIL;
         free_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      force_ff  <= force_in;
      plink_ff  <= plink_in;
      pvalue_ff <= pvalue_in;
      tgt_ff    <= tgt_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      vout_ff   <= vout_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/array_linked_list_manager.sv */
// Linked list kept in a node memory of NODES entries, with a free list.
// Request channel (req_*): one request per operation; opcode selects append
// at tail, insert after a node, delete a node or delete its successor.
// Response channel (rsp_*): exactly one response per request with status,
// the node allocated or freed, the removed value and the free-list head.
// Each request passes the sequencer steps decode, position read (not for
// append), take, link, walk and free as its opcode needs, and then its
// response goes into the response register; the next request is taken only
// after the sequencer returns to idle.
// The walks for append and delete read one node per cycle from the single
// read port of the node memory, so the time to respond grows with the walk.
// req_tready is high only while the sequencer is idle, one request at a time.
// After reset a clearing pass over all NODES nodes rebuilds the free list,
// and req_tready stays low until it is done.
// A stalled response waits in the output register; the next request is
// taken meanwhile and held in its last state until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_manager
   import alm_pkg::*;
#(
   parameter int NODES = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: opcode, position, value_in; zero padded.
   input  wire logic [REQ_W-1:0]         req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // Fields from bit 0: status, slot, value_out, free_head; zero padded.
   output logic [((2*$clog2(NODES+1)+STS_W+VALUE_W+7)/8)*8-1:0] rsp_tdata
);

   localparam int LW    = $clog2(NODES + 1);
   localparam int AW    = $clog2(NODES);
   localparam int WW    = LW + VALUE_W + 1;
   localparam int USE_W = 2 * LW + STS_W + VALUE_W;
   localparam int RSP_W = ((USE_W + 7) / 8) * 8;

   logic               start;
   logic               idle;
   logic               res_valid;
   logic               res_take;
   status_type         res_status;
   logic [LW-1:0]      res_slot;
   logic [VALUE_W-1:0] res_value;
   logic [LW-1:0]      res_free_head;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [WW-1:0]      ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [WW-1:0]      ram_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // Request handshake.
   assign req_tready = idle;
   assign start      = req_tvalid && idle;

   alm_ctrl #(
      .NODES(NODES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .op            (op_type'(req_tdata[OP_W-1:0])),
      .pos           (req_tdata[OP_W +: POS_W]),
      .val           (req_tdata[OP_W+POS_W +: VALUE_W]),
      .idle          (idle),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res_status    (res_status),
      .res_slot      (res_slot),
      .res_value     (res_value),
      .res_free_head (res_free_head),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   alm_node_ram #(
      .DEPTH(NODES),
      .WIDTH(WW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Response register: load when empty or being drained.
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = res_take
                       ? RSP_W'({res_free_head, res_value, res_slot, res_status})
                       : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* sim/array_linked_list_manager_tb.sv */
`timescale 1ns / 1ps

module array_linked_list_manager_tb;
   import alm_pkg::*;

   localparam int NODES       = 16;
   localparam logic [4:0] NIL = 5'(NODES);
   localparam int RSP_W       = ((2*$clog2(NODES+1)+STS_W+VALUE_W+7)/8)*8;
   localparam int CYCLE_LIMIT = 400000;

   // One expected response of the list manager.
   typedef struct {
      status_type  status;
      logic [4:0]  slot;
      logic [31:0] value_out;
      logic [4:0]  free_head;
   } list_result_type;

   // Shadow copy of the node memory; predicts each response and checks it.
   class list_scoreboard;
      logic [31:0] node_val [NODES];
      logic [4:0]  node_next [NODES];
      bit          node_busy [NODES];
      logic [4:0]  free_ptr;
      logic [4:0]  head;
      list_result_type predicted_rsp[$];
      int          errors;

      function new();
         for (int i = 0; i < NODES; i++) begin
            node_val[i]  = '0;
            node_next[i] = 5'(i + 1);
            node_busy[i] = 1'b0;
         end
         node_next[NODES-1] = NIL;
         free_ptr = '0;
         head     = NIL;
         errors   = 0;
      endfunction

      function int outstanding();
         return predicted_rsp.size();
      endfunction

      function int list_size();
         int n;
         n = 0;
         for (int i = 0; i < NODES; i++) n += node_busy[i];
         return n;
      endfunction

      // Random node that is currently in the list, or any index if empty.
      function logic [3:0] random_busy_node();
         int k;
         k = $urandom_range(NODES - 1);
         for (int i = 0; i < NODES; i++)
            if (node_busy[(k + i) % NODES]) return 4'((k + i) % NODES);
         return 4'(k);
      endfunction

      function void release_node(logic [4:0] p);
         node_val[p]  = '0;
         node_busy[p] = 1'b0;
         node_next[p] = free_ptr;
         free_ptr     = p;
      endfunction

      // Apply one accepted request to the shadow list and queue its response.
      function void note_request(op_type op, logic [3:0] pos, logic [31:0] v);
         list_result_type r;
         logic [4:0]   p;
         logic [4:0]   t;
         bit           found;
         int           n;
         r.status    = STS_OK;
         r.slot      = NIL;
         r.value_out = '0;
         case (op)
            OP_APPEND: begin
               if (free_ptr == NIL) begin
                  r.status = STS_NO_FREE;
               end else begin
                  p = free_ptr;
                  free_ptr = node_next[p];
                  node_val[p]  = v;
                  node_next[p] = NIL;
                  node_busy[p] = 1'b1;
                  if (head == NIL) begin
                     head = p;
                  end else begin
                     // Walk to the tail, bounded to the node count.
                     t = head;
                     n = 0;
                     while (n < NODES && node_next[t] != NIL) begin
                        t = node_next[t];
                        n++;
                     end
                     node_next[t] = p;
                  end
                  r.slot = p;
               end
            end
            OP_INSERT: begin
               if (!node_busy[pos]) begin
                  r.status = STS_BAD_POS;
               end else if (free_ptr == NIL) begin
                  r.status = STS_NO_FREE;
               end else begin
                  p = free_ptr;
                  free_ptr = node_next[p];
                  node_val[p]    = v;
                  node_busy[p]   = 1'b1;
                  node_next[p]   = node_next[pos];
                  node_next[pos] = p;
                  r.slot = p;
               end
            end
            OP_DELETE: begin
               if (!node_busy[pos]) begin
                  r.status = STS_BAD_POS;
               end else if (head == 5'(pos)) begin
                  head        = node_next[pos];
                  r.value_out = node_val[pos];
                  r.slot      = 5'(pos);
                  release_node(5'(pos));
               end else begin
                  // Search for the predecessor of the node being removed.
                  t = head;
                  found = 1'b0;
                  n = 0;
                  while (!found && n < NODES && t != NIL) begin
                     if (node_next[t] == 5'(pos)) begin
                        found = 1'b1;
                     end else begin
                        t = node_next[t];
                        n++;
                     end
                  end
                  if (!found) begin
                     r.status = STS_NO_LINK;
                  end else begin
                     node_next[t] = node_next[pos];
                     r.value_out  = node_val[pos];
                     r.slot       = 5'(pos);
                     release_node(5'(pos));
                  end
               end
            end
            default: begin
               if (!node_busy[pos]) begin
                  r.status = STS_BAD_POS;
               end else if (node_next[pos] == NIL) begin
                  r.status = STS_NO_LINK;
               end else begin
                  p = node_next[pos];
                  node_next[pos] = node_next[p];
                  r.value_out    = node_val[p];
                  r.slot         = p;
                  release_node(p);
               end
            end
         endcase
         r.free_head = free_ptr;
         predicted_rsp.push_back(r);
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(logic [RSP_W-1:0] d);
         list_result_type r;
         if (predicted_rsp.size() == 0) begin
            $error("response 0x%h arrived with no request outstanding", d);
            errors++;
            return;
         end
         r = predicted_rsp.pop_front();
         if (d[1:0] != r.status) begin
            $error("status: expected %0d, actual %0d", r.status, d[1:0]);
            errors++;
         end
         if (d[6:2] != r.slot) begin
            $error("slot: expected %0d, actual %0d", r.slot, d[6:2]);
            errors++;
         end
         if (d[38:7] != r.value_out) begin
            $error("value_out: expected %0d, actual %0d",
                   $signed(r.value_out), $signed(d[38:7]));
            errors++;
         end
         if (d[43:39] != r.free_head) begin
            $error("free_head: expected %0d, actual %0d", r.free_head, d[43:39]);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   list_scoreboard sb = new();

   array_linked_list_manager #(.NODES(NODES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response side: check each accepted response, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Offer one request, idling at random first, and wait for its acceptance.
   task automatic issue_list_op(op_type op, logic [3:0] pos, logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, v, pos, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, pos, v);
   endtask

   // Stop offering until every predicted response has come back.
   task automatic wait_all_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (NODES + 8) @(posedge clock);
   endtask

   // Random request biased to keep the list away from both empty and full.
   task automatic random_list_op();
      int         size;
      int         roll;
      op_type     op;
      logic [3:0] pos;
      size = sb.list_size();
      roll = $urandom_range(99);
      if (size < 3)
         op = roll < 60 ? OP_APPEND : roll < 80 ? OP_INSERT :
              roll < 90 ? OP_DELETE : OP_DEL_SUCC;
      else if (size > 13)
         op = roll < 15 ? OP_APPEND : roll < 30 ? OP_INSERT :
              roll < 70 ? OP_DELETE : OP_DEL_SUCC;
      else
         op = roll < 30 ? OP_APPEND : roll < 50 ? OP_INSERT :
              roll < 80 ? OP_DELETE : OP_DEL_SUCC;
      if ($urandom_range(99) < 85) pos = sb.random_busy_node();
      else pos = 4'($urandom_range(NODES - 1));
      issue_list_op(op, pos, $urandom());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, bad positions, fill to full, head and tail removal.
      issue_list_op(OP_APPEND, 4'd9, 32'h7fff_ffff);
      issue_list_op(OP_DEL_SUCC, 4'd0, 32'h0);
      issue_list_op(OP_INSERT, 4'd5, 32'h1234_5678);
      issue_list_op(OP_DELETE, 4'd15, 32'h0);
      issue_list_op(OP_DEL_SUCC, 4'd15, 32'h0);
      issue_list_op(OP_APPEND, 4'd15, 32'h8000_0000);
      issue_list_op(OP_APPEND, 4'd0, 32'hffff_ffff);
      issue_list_op(OP_APPEND, 4'd3, 32'h0);
      for (int i = 0; i < 12; i++) issue_list_op(OP_APPEND, 4'(i), $urandom());
      issue_list_op(OP_APPEND, 4'd0, 32'hdead_beef);
      issue_list_op(OP_INSERT, 4'd15, 32'h5555_aaaa);
      issue_list_op(OP_DELETE, 4'd0, 32'h0);
      issue_list_op(OP_DELETE, 4'd15, 32'h0);
      issue_list_op(OP_DEL_SUCC, 4'd7, 32'h0);
      issue_list_op(OP_INSERT, 4'd14, 32'hffff_ffff);
      wait_all_done();

      // Random: three idling patterns, the last one starting with a long stall.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 29 : phase == 1 ? 79 : 0;
         take_idle_pct = phase == 0 ? 79 : phase == 1 ? 29 : 0;
         if (phase == 2) hold_left = 300;
         for (int i = 0; i < 460; i++) random_list_op();
         wait_all_done();
      end

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (sb.outstanding() != 0)
            $error("%0d responses never arrived", sb.outstanding());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
